@@ rtl/adaptive_median_filter_top_macros.svh @@
// Assertion macros for the adaptive median filter.
`ifndef ADAPTIVE_MEDIAN_FILTER_TOP_MACROS_SVH
`define ADAPTIVE_MEDIAN_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define AMF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("adaptive median filter check failed");
`define AMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("adaptive median filter check failed");
`else
`define AMF_ASSERT_SAME(label, ante, cons)
`define AMF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/amf_pkg.sv @@
// Shared constants for the adaptive median filter.
package amf_pkg;
    localparam int PIX_W      = 8;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int LW_W       = 12;
    localparam int FH_W       = 13;
    localparam int RAD_W      = 3;
    localparam int SLOT_W     = 4;
    localparam int LINES      = 15;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 7;
    localparam int WIN_DEPTH  = 225;
    localparam int IDX_W      = 8;
    localparam int LS_AW      = SLOT_W + COL_W;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RADIUS   = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RADIUS   = 8'd3;

    typedef logic [PIX_W-1:0] pix_t;
endpackage

@@ rtl/adaptive_median_filter_top.sv @@
// Adaptive median filter: line store, window store and bit-serial rank unit.
//
// Usage: 8-bit pixels of a border-padded frame enter on the s_ channel in
// raster order; s_tuser flags the first pixel of a frame. Each pixel that
// completes a full window of the largest radius R yields one request on the
// m_ channel: the filtered pixel R rows up and R columns left, with tlast on
// the last result of a row and tuser on the last of the frame. Pixels that
// complete no window give nothing and leave the block idle.
// Registers are written on the cfg channel (0 line width, 1 frame height,
// 2 min radius, 3 max radius); the user must write them only while the block
// is idle, as the block itself does not enforce it.
// Flow: each window radius r tried (n = (2r+1)^2 pixels) copies the window
// from the line store into the window store, then finds the bit-serial
// median, one bit of the median per pass over the window store, then decides
// whether to try the next radius. One pixel is worked on at a time.
// Reset: positions clear, registers return to 2048 x 4096, radii 1 to 7; the
// stores hold nothing defined until written, and no clearing pass is run.
// Stall: the output register holds its request until taken; the next pixel
// is still accepted, and only a new result waits for the register to empty.
`include "adaptive_median_filter_top_macros.svh"

module adaptive_median_filter_top import amf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    input  logic [0:0]            s_tuser,   // [0] first_of_frame
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] filtered
    output logic                  m_tlast,   // last_of_row
    output logic [0:0]            m_tuser,   // [0] last_of_frame
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_LDRAIN = 3'd2;
    localparam logic [2:0] ST_RANK   = 3'd3;
    localparam logic [2:0] ST_RSTEP  = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINES - 1);

    // (a - b) mod LINES for a below LINES and b at most MAX_RADIUS
    function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] a,
                                                   input logic [RAD_W-1:0] b);
        logic [SLOT_W:0] t;
        t = {1'b0, a} + (SLOT_W+1)'(LINES) - {2'b00, b};
        if (t >= (SLOT_W+1)'(LINES)) begin
            t = t - (SLOT_W+1)'(LINES);
        end
        return t[SLOT_W-1:0];
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [LW_W-1:0]   lw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [RAD_W-1:0]  rmin_reg, rmax_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOT_W-1:0] rm_reg;
    logic [SLOT_W-1:0] cm_reg;
    logic [COL_W-1:0]  cc_reg;
    logic              lr_reg, lf_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [COL_W-1:0]  colp_reg, cs_reg;
    logic [3:0]        ci_reg, d2_reg;
    logic [IDX_W-1:0]  idx_reg, n_reg;
    logic              ld_v_reg;
    logic [IDX_W-1:0]  ld_idx_reg;
    pix_t              lsq_reg;
    pix_t              lo_reg, hi_reg, ctr_reg;
    pix_t              pfx_reg, mask_reg, sel_reg, wq_reg;
    logic [IDX_W-1:0]  k_reg, cnt_reg;
    logic              rk_v_reg;
    logic              m_tvalid_reg, m_last_reg, m_user_reg;
    pix_t              m_data_reg;

    pix_t ls_mem [0:2**LS_AW-1];
    pix_t win_mem [0:WIN_DEPTH-1];

    // effective configuration
    logic [LW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [RAD_W-1:0] rmax_eff, rmin_c, rmin_eff;

    always_comb begin
        if (lw_reg == '0) begin
            w_eff = LW_W'(1);
        end else if (lw_reg > LW_W'(MAX_WIDTH)) begin
            w_eff = LW_W'(MAX_WIDTH);
        end else begin
            w_eff = lw_reg;
        end
        if (fh_reg == '0) begin
            h_eff = FH_W'(1);
        end else if (fh_reg > FH_W'(MAX_HEIGHT)) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = fh_reg;
        end
        rmax_eff = (rmax_reg == '0) ? RAD_W'(1) : rmax_reg;
        rmin_c   = (rmin_reg == '0) ? RAD_W'(1) : rmin_reg;
        rmin_eff = (rmin_c > rmax_eff) ? rmax_eff : rmin_c;
    end

    // position of the incoming pixel
    logic              accept, first;
    logic [COL_W-1:0]  c0, c1;
    logic [ROW_W-1:0]  r0, r2;
    logic [ROW_W:0]    r1;
    logic [SLOT_W-1:0] m0, m1, m2;
    logic              wrap_c, wrap_r, need, last_c, last_r;
    logic [3:0]        two_r;
    logic [ROW_W:0]    r2_inc;
    logic [COL_W-1:0]  col_nx;
    logic [ROW_W-1:0]  row_nx;
    logic [SLOT_W-1:0] rm_nx;

    assign accept = s_tvalid && s_tready;
    assign first  = s_tuser[0];

    always_comb begin
        c0     = first ? '0 : col_reg;
        r0     = first ? '0 : row_reg;
        m0     = first ? '0 : rm_reg;
        wrap_c = {1'b0, c0} >= w_eff;
        c1     = wrap_c ? '0 : c0;
        r1     = wrap_c ? ({1'b0, r0} + (ROW_W+1)'(1)) : {1'b0, r0};
        m1     = wrap_c ? ((m0 == LAST_SLOT) ? '0 : m0 + SLOT_W'(1)) : m0;
        wrap_r = r1 >= h_eff;
        r2     = wrap_r ? '0 : r1[ROW_W-1:0];
        m2     = wrap_r ? '0 : m1;
        two_r  = {1'b0, rmax_eff} << 1;
        need   = (r2 >= ROW_W'(two_r)) && (c1 >= COL_W'(two_r));
        last_c = ({1'b0, c1} + LW_W'(1)) >= w_eff;
        r2_inc = {1'b0, r2} + (ROW_W+1)'(1);
        last_r = r2_inc >= h_eff;
        col_nx = last_c ? '0 : c1 + COL_W'(1);
        row_nx = last_c ? (last_r ? '0 : r2_inc[ROW_W-1:0]) : r2;
        rm_nx  = last_c ? ((last_r || m2 == LAST_SLOT) ? '0 : m2 + SLOT_W'(1)) : m2;
    end

    // window setup for the first or the next radius
    logic [RAD_W-1:0]  su_rad;
    logic [SLOT_W-1:0] su_cm, su_slot;
    logic [COL_W-1:0]  su_cc, su_cs;
    logic [3:0]        su_d;
    logic [IDX_W-1:0]  su_n;

    always_comb begin
        if (state_reg == ST_IDLE) begin
            su_rad = rmin_eff;
            su_cm  = slot_sub(m2, rmax_eff);
            su_cc  = c1 - COL_W'(rmax_eff);
        end else begin
            su_rad = rad_reg + RAD_W'(1);
            su_cm  = cm_reg;
            su_cc  = cc_reg;
        end
        su_slot = slot_sub(su_cm, su_rad);
        su_cs   = su_cc - COL_W'(su_rad);
        su_d    = {su_rad, 1'b1};
        su_n    = {4'b0000, su_d} * {4'b0000, su_d};
    end

    // rank count and decision
    logic             match;
    logic [IDX_W-1:0] cnt_fin;
    logic             med_ok, ctr_ok, done_rad, out_free;
    pix_t             result;

    always_comb begin
        match    = (((wq_reg ^ pfx_reg) & mask_reg) == '0) && ((wq_reg & sel_reg) == '0);
        cnt_fin  = cnt_reg + IDX_W'(match);
        med_ok   = (pfx_reg > lo_reg) && (pfx_reg < hi_reg);
        ctr_ok   = (ctr_reg > lo_reg) && (ctr_reg < hi_reg);
        done_rad = med_ok || (rad_reg == rmax_eff);
        result   = (med_ok && ctr_ok) ? ctr_reg : pfx_reg;
        out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && need) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (idx_reg == n_reg - IDX_W'(1)) begin
                    state_next = ST_LDRAIN;
                end
            end
            ST_LDRAIN: state_next = ST_RANK;
            ST_RANK: begin
                if (idx_reg == n_reg - IDX_W'(1)) begin
                    state_next = ST_RSTEP;
                end
            end
            ST_RSTEP: state_next = (sel_reg == pix_t'(1)) ? ST_DECIDE : ST_RANK;
            ST_DECIDE: begin
                if (!done_rad) begin
                    state_next = ST_LOAD;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_user_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lw_reg       <= LW_W'(MAX_WIDTH);
            fh_reg       <= FH_W'(MAX_HEIGHT);
            rmin_reg     <= RAD_W'(1);
            rmax_reg     <= RAD_W'(MAX_RADIUS);
            col_reg      <= '0;
            row_reg      <= '0;
            rm_reg       <= '0;
            ld_v_reg     <= 1'b0;
            rk_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ld_v_reg  <= (state_reg == ST_LOAD);
            rk_v_reg  <= (state_reg == ST_RANK);
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_LINE_WIDTH:   lw_reg   <= cfg_data[LW_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg   <= cfg_data[FH_W-1:0];
                    REG_MIN_RADIUS:   rmin_reg <= cfg_data[RAD_W-1:0];
                    REG_MAX_RADIUS:   rmax_reg <= cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg <= col_nx;
                row_reg <= row_nx;
                rm_reg  <= rm_nx;
            end
            if (state_reg == ST_DECIDE && done_rad && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE && accept && need) ||
            (state_reg == ST_DECIDE && !done_rad)) begin
            rad_reg  <= su_rad;
            cm_reg   <= su_cm;
            cc_reg   <= su_cc;
            slot_reg <= su_slot;
            colp_reg <= su_cs;
            cs_reg   <= su_cs;
            ci_reg   <= '0;
            d2_reg   <= su_d - 4'd1;
            idx_reg  <= '0;
            n_reg    <= su_n;
            lo_reg   <= '1;
            hi_reg   <= '0;
        end
        if (state_reg == ST_IDLE && accept && need) begin
            lr_reg <= last_c;
            lf_reg <= last_c && last_r;
        end
        if (state_reg == ST_LOAD) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (ci_reg == d2_reg) begin
                ci_reg   <= '0;
                colp_reg <= cs_reg;
                slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
            end else begin
                ci_reg   <= ci_reg + 4'd1;
                colp_reg <= colp_reg + COL_W'(1);
            end
        end
        if (ld_v_reg) begin
            if (lsq_reg < lo_reg) lo_reg <= lsq_reg;
            if (lsq_reg > hi_reg) hi_reg <= lsq_reg;
            if (ld_idx_reg == (n_reg >> 1)) ctr_reg <= lsq_reg;
        end
        ld_idx_reg <= idx_reg;
        if (state_reg == ST_LDRAIN) begin
            idx_reg  <= '0;
            pfx_reg  <= '0;
            mask_reg <= '0;
            sel_reg  <= pix_t'(8'h80);
            k_reg    <= n_reg >> 1;
            cnt_reg  <= '0;
        end
        if (state_reg == ST_RANK) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (rk_v_reg) cnt_reg <= cnt_fin;
        end
        if (state_reg == ST_RSTEP) begin
            if (k_reg >= cnt_fin) begin
                pfx_reg <= pfx_reg | sel_reg;
                k_reg   <= k_reg - cnt_fin;
            end
            mask_reg <= mask_reg | sel_reg;
            sel_reg  <= sel_reg >> 1;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end
        if (state_reg == ST_DECIDE && done_rad && out_free) begin
            m_data_reg <= result;
            m_last_reg <= lr_reg;
            m_user_reg <= lf_reg;
        end
    end

    // line store: written on each accepted pixel, read while copying a window
    always_ff @(posedge aclk) begin
        if (accept) begin
            ls_mem[{m2, c1}] <= s_tdata[PIX_W-1:0];
        end
        if (state_reg == ST_LOAD) begin
            lsq_reg <= ls_mem[{slot_reg, colp_reg}];
        end
    end

    // window store
    always_ff @(posedge aclk) begin
        if (ld_v_reg) begin
            win_mem[ld_idx_reg] <= lsq_reg;
        end
        if (state_reg == ST_RANK) begin
            wq_reg <= win_mem[idx_reg];
        end
    end

    `AMF_ASSERT_SAME(a_count_bound, state_reg == ST_RSTEP, cnt_fin <= n_reg)
    `AMF_ASSERT_SAME(a_radius_range, state_reg != ST_IDLE, rad_reg >= rmin_eff && rad_reg <= rmax_eff)
    `AMF_ASSERT_SAME(a_median_span, state_reg == ST_DECIDE, lo_reg <= pfx_reg && pfx_reg <= hi_reg)
    `AMF_ASSERT_NEXT(a_start_load, state_reg == ST_IDLE && accept && need, state_reg == ST_LOAD)

endmodule
